@@ rtl/core/assert_macros.svh @@
// Assertion macros for the tokenizer RTL.
// Depends on nothing; the bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising edge outside reset.
`define SBT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tokenizer assertion failed");
// Implication checked at every rising edge outside reset.
`define SBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer implication failed");
`else
`define SBT_ASSERT(label, clk, rst_n, prop)
`define SBT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/sbt_pkg.sv @@
// Shared types, codes and character helpers of the byte tokenizer.
// Depends on nothing.
`timescale 1ns / 1ps
package sbt_pkg;

    localparam int unsigned MAX_SOURCE_BYTES_DEF = 1048576;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Token classes.
    localparam logic [2:0] CLS_CHAR    = 3'd0;
    localparam logic [2:0] CLS_END     = 3'd1;
    localparam logic [2:0] CLS_INT     = 3'd2;
    localparam logic [2:0] CLS_FLOAT   = 3'd3;
    localparam logic [2:0] CLS_NAME    = 3'd4;
    localparam logic [2:0] CLS_KEYWORD = 3'd5;
    localparam logic [2:0] CLS_STRING  = 3'd6;

    // Error codes.
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_DIGIT   = 3'd1;
    localparam logic [2:0] ERR_OVF     = 3'd2;
    localparam logic [2:0] ERR_EXP     = 3'd3;
    localparam logic [2:0] ERR_NONPRT  = 3'd4;
    localparam logic [2:0] ERR_UNTERM  = 3'd5;

    // Radix codes.
    localparam logic [1:0] RAD_DEC = 2'd0;
    localparam logic [1:0] RAD_HEX = 2'd1;
    localparam logic [1:0] RAD_BIN = 2'd2;
    localparam logic [1:0] RAD_OCT = 2'd3;

    // Token payload without offsets.
    typedef struct packed {
        logic [2:0]  cls;
        logic [7:0]  chr;
        logic [1:0]  rad;
        logic [63:0] val;
        logic [2:0]  kw;
        logic [2:0]  err;
    } t_tok;

    typedef struct packed {
        logic       found;
        logic [2:0] idx;
    } t_kw;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // Digit value, 16 when the byte is no hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (is_dig(c)) v = 5'(c - 8'h30);
        else if ((c >= 8'h61) && (c <= 8'h66)) v = 5'(c - 8'h57);
        else if ((c >= 8'h41) && (c <= 8'h46)) v = 5'(c - 8'h37);
        return v;
    endfunction

    // Keyword lookup over the six-byte prefix, first byte in the low bits.
    function automatic t_kw kw_lookup(input logic [47:0] p, input logic [2:0] n);
        t_kw r;
        r = '{found: 1'b0, idx: 3'd0};
        if (n == 3'd4 && p[31:0] == 32'h6d_75_6e_65) r = '{1'b1, 3'd0};
        else if (n == 3'd6 && p == 48'h74_63_75_72_74_73) r = '{1'b1, 3'd1};
        else if (n == 3'd5 && p[39:0] == 40'h6e_6f_69_6e_75) r = '{1'b1, 3'd2};
        else if (n == 3'd3 && p[23:0] == 24'h72_61_76) r = '{1'b1, 3'd3};
        else if (n == 3'd5 && p[39:0] == 40'h74_73_6e_6f_63) r = '{1'b1, 3'd4};
        else if (n == 3'd4 && p[31:0] == 32'h63_6e_75_66) r = '{1'b1, 3'd5};
        return r;
    endfunction

endpackage

@@ rtl/core/sbt_scan.sv @@
// Token scanner: state registers and the per-byte next-state logic.
// Depends on sbt_pkg; produces up to two tokens per accepted byte.
`timescale 1ns / 1ps
module sbt_scan
    import sbt_pkg::*;
#(
    parameter int unsigned MAX_SOURCE_BYTES = MAX_SOURCE_BYTES_DEF,
    localparam int unsigned SW = $clog2(MAX_SOURCE_BYTES),
    localparam int unsigned PW = SW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    input  logic          i_sos,
    output logic [1:0]    o_count,
    output t_tok          o_tok0,
    output t_tok          o_tok1,
    output logic [SW-1:0] o_so0,
    output logic [SW-1:0] o_so1,
    output logic [PW-1:0] o_eo0,
    output logic [PW-1:0] o_eo1
);

    typedef enum logic [3:0] {
        M_IDLE, M_WS, M_ZERO, M_NUM, M_SKIP, M_FRAC,
        M_EXP, M_SIGN, M_EXPD, M_NAME, M_STR
    } t_mode;

    localparam logic [PW-1:0] POS_MAX = PW'(MAX_SOURCE_BYTES);
    localparam logic [SW-1:0] START_MAX = SW'(MAX_SOURCE_BYTES - 1);

    t_mode         r_mode, n_mode;
    logic [63:0]   r_acc, n_acc;
    logic [1:0]    r_rad, n_rad;
    logic          r_alldec, n_alldec;
    logic [SW-1:0] r_ts, n_ts;
    logic [PW-1:0] r_pos, n_pos;
    logic [47:0]   r_nbuf, n_nbuf;
    logic [2:0]    r_nlen, n_nlen;
    logic [2:0]    r_ferr, n_ferr;

    // Next-state logic, written in the order the byte is examined.
    always_comb begin
        logic [7:0]  c;
        logic        dig;
        logic [4:0]  hv;
        logic [4:0]  d;
        logic [4:0]  base;
        logic [67:0] prod;
        logic [67:0] sum;
        logic [PW-1:0] cp, e_here, e_after;
        logic        p1, st, do_num, do_intc, do_acc, fin, ws;
        t_tok        t1;
        logic [PW-1:0] e1;
        t_kw         kwr;
        c = i_byte;
        dig = is_dig(c);
        hv = hex_val(c);
        n_mode = r_mode; n_acc = r_acc; n_rad = r_rad; n_alldec = r_alldec;
        n_ts = r_ts; n_pos = r_pos; n_nbuf = r_nbuf; n_nlen = r_nlen; n_ferr = r_ferr;
        o_count = 2'd0;
        o_tok0 = '0; o_tok1 = '0;
        o_so0 = '0; o_so1 = '0; o_eo0 = '0; o_eo1 = '0;
        p1 = 1'b0; st = 1'b0; do_num = 1'b0; do_intc = 1'b0; do_acc = 1'b0; fin = 1'b0;
        t1 = '0; e1 = '0;
        d = 5'd0; base = 5'd10; prod = '0; sum = '0;
        kwr = kw_lookup(r_nbuf, r_nlen);
        ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) || (c == 8'h0D);
        if (i_sos) begin
            n_mode = M_IDLE; n_acc = '0; n_rad = RAD_DEC; n_alldec = 1'b1;
            n_nbuf = '0; n_nlen = '0; n_ferr = ERR_NONE; n_ts = '0; n_pos = '0;
        end
        cp = n_pos;
        e_here = cp;
        e_after = (cp < POS_MAX) ? cp + PW'(1) : POS_MAX;

        // First pass: continue or close the current token.
        case (n_mode)
            M_WS: begin
                if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))) st = 1'b1;
            end
            M_ZERO: begin
                if (c == 8'h2E) begin
                    n_ferr = ERR_NONE; n_acc = '0; n_rad = RAD_DEC; n_mode = M_FRAC;
                end else if (c == 8'h65 || c == 8'h45) begin
                    n_ferr = ERR_NONE; n_acc = '0; n_rad = RAD_DEC; n_mode = M_EXP;
                end else if (c == 8'h78 || c == 8'h58) begin
                    n_rad = RAD_HEX; n_alldec = 1'b0; n_mode = M_NUM;
                end else if (c == 8'h62 || c == 8'h42) begin
                    n_rad = RAD_BIN; n_alldec = 1'b0; n_mode = M_NUM;
                end else if (dig) begin
                    n_rad = RAD_OCT; n_mode = M_NUM; do_num = 1'b1;
                end else begin
                    n_rad = RAD_DEC; n_mode = M_NUM; do_intc = 1'b1;
                end
            end
            M_NUM: do_num = 1'b1;
            M_SKIP: begin
                if (!dig) begin
                    if (n_alldec && c == 8'h2E) begin
                        n_ferr = ERR_NONE; n_acc = '0; n_rad = RAD_DEC; n_mode = M_FRAC;
                    end else if (n_alldec && (c == 8'h65 || c == 8'h45)) begin
                        n_ferr = ERR_NONE; n_acc = '0; n_rad = RAD_DEC; n_mode = M_EXP;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            M_FRAC: begin
                if (!dig) begin
                    if (c == 8'h65 || c == 8'h45) n_mode = M_EXP;
                    else begin
                        p1 = 1'b1; st = 1'b1; t1.cls = CLS_FLOAT; e1 = e_here;
                    end
                end
            end
            M_EXP: begin
                if (c == 8'h2B || c == 8'h2D) n_mode = M_SIGN;
                else if (dig) n_mode = M_EXPD;
                else begin
                    if (n_ferr == ERR_NONE) n_ferr = ERR_EXP;
                    p1 = 1'b1; st = 1'b1; t1.cls = CLS_FLOAT; e1 = e_here;
                end
            end
            M_SIGN: begin
                if (dig) n_mode = M_EXPD;
                else begin
                    if (n_ferr == ERR_NONE) n_ferr = ERR_EXP;
                    p1 = 1'b1; st = 1'b1; t1.cls = CLS_FLOAT; e1 = e_here;
                end
            end
            M_EXPD: begin
                if (!dig) begin
                    p1 = 1'b1; st = 1'b1; t1.cls = CLS_FLOAT; e1 = e_here;
                end
            end
            M_NAME: begin
                if (is_alpha(c) || dig || c == 8'h5F) begin
                    if (n_nlen < 3'd6) n_nbuf[8*n_nlen +: 8] = c;
                    if (n_nlen < 3'd7) n_nlen = n_nlen + 3'd1;
                end else begin
                    p1 = 1'b1; st = 1'b1; e1 = e_here;
                    t1.cls = kwr.found ? CLS_KEYWORD : CLS_NAME;
                    t1.kw = kwr.found ? kwr.idx : 3'd0;
                end
            end
            M_STR: begin
                if (c == 8'h22) begin
                    p1 = 1'b1; t1.cls = CLS_STRING; e1 = e_after;
                end else if (c == 8'h00) begin
                    if (n_ferr == ERR_NONE) n_ferr = ERR_UNTERM;
                    p1 = 1'b1; st = 1'b1; t1.cls = CLS_STRING; e1 = e_here;
                end else if (c < 8'h20 || c > 8'h7E) begin
                    if (n_ferr == ERR_NONE) n_ferr = ERR_NONPRT;
                end
            end
            default: st = 1'b1;
        endcase

        // Number continuation shared by the zero and digit-run modes.
        if (do_num) begin
            if (n_alldec && dig) do_acc = 1'b1;
            else if (n_alldec && c == 8'h2E) begin
                n_ferr = ERR_NONE; n_acc = '0; n_rad = RAD_DEC; n_mode = M_FRAC;
            end else if (n_alldec && (c == 8'h65 || c == 8'h45)) begin
                n_ferr = ERR_NONE; n_acc = '0; n_rad = RAD_DEC; n_mode = M_EXP;
            end else do_intc = 1'b1;
        end
        if (do_intc) begin
            n_alldec = 1'b0;
            if (hv < 5'd16) do_acc = 1'b1;
            else fin = 1'b1;
        end

        // Multiply-add by the radix, built from shifts.
        if (do_acc) begin
            case (n_rad)
                RAD_HEX: base = 5'd16;
                RAD_BIN: base = 5'd2;
                RAD_OCT: base = 5'd8;
                default: base = 5'd10;
            endcase
            d = hv;
            if (d >= base) begin
                if (n_ferr == ERR_NONE) n_ferr = ERR_DIGIT;
                d = 5'd0;
            end
            case (n_rad)
                RAD_HEX: prod = {n_acc, 4'b0};
                RAD_BIN: prod = {3'b0, n_acc, 1'b0};
                RAD_OCT: prod = {1'b0, n_acc, 3'b0};
                default: prod = {1'b0, n_acc, 3'b0} + {3'b0, n_acc, 1'b0};
            endcase
            sum = prod + 68'(d);
            if (sum[67:64] != 4'd0) begin
                if (n_ferr == ERR_NONE) n_ferr = ERR_OVF;
                n_acc = '0;
                if (dig) n_mode = M_SKIP;
                else fin = 1'b1;
            end else begin
                n_acc = sum[63:0];
            end
        end
        if (fin) begin
            p1 = 1'b1; st = 1'b1; t1.cls = CLS_INT; t1.rad = n_rad; t1.val = n_acc;
            e1 = e_here;
        end

        // Emit the closed token and clear the token state.
        if (p1) begin
            t1.err = n_ferr;
            o_tok0 = t1; o_so0 = n_ts; o_eo0 = e1; o_count = 2'd1;
            n_mode = M_IDLE; n_acc = '0; n_rad = RAD_DEC; n_alldec = 1'b1;
            n_nbuf = '0; n_nlen = '0; n_ferr = ERR_NONE;
        end

        // Second pass: this byte opens the next token.
        if (st) begin
            n_mode = M_IDLE;
            if (ws) n_mode = M_WS;
            else begin
                n_ts = (cp < POS_MAX) ? cp[SW-1:0] : START_MAX;
                if (c == 8'h22) n_mode = M_STR;
                else if (c == 8'h2E) n_mode = M_FRAC;
                else if (c == 8'h30) n_mode = M_ZERO;
                else if (dig) begin
                    n_mode = M_NUM; n_acc = 64'(hv);
                end else if (is_alpha(c) || c == 8'h5F) begin
                    n_mode = M_NAME; n_nbuf[7:0] = c; n_nlen = 3'd1;
                end else begin
                    t1 = '0;
                    t1.cls = (c == 8'h00) ? CLS_END : CLS_CHAR;
                    t1.chr = c;
                    t1.err = n_ferr;
                    if (o_count == 2'd0) begin
                        o_tok0 = t1; o_so0 = n_ts; o_eo0 = e_after;
                    end else begin
                        o_tok1 = t1; o_so1 = n_ts; o_eo1 = e_after;
                    end
                    o_count = o_count + 2'd1;
                end
            end
        end
        n_pos = e_after;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc <= '0;
            r_rad <= RAD_DEC;
            r_alldec <= 1'b1;
            r_ts <= '0;
            r_pos <= '0;
            r_nbuf <= '0;
            r_nlen <= '0;
            r_ferr <= ERR_NONE;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_acc <= n_acc;
            r_rad <= n_rad;
            r_alldec <= n_alldec;
            r_ts <= n_ts;
            r_pos <= n_pos;
            r_nbuf <= n_nbuf;
            r_nlen <= n_nlen;
            r_ferr <= n_ferr;
        end
    end

endmodule

@@ rtl/core/sbt_outq.sv @@
// Result queue: takes up to two entries per cycle, hands out one.
// Depends on sbt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sbt_outq
    import sbt_pkg::*;
#(
    parameter int unsigned DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_n,
    input  logic [DATA_W-1:0] i_data0,
    input  logic [DATA_W-1:0] i_data1,
    output logic              o_space2,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]     r_head, r_tail;
    logic [AW:0]       r_cnt, n_cnt;
    logic              pop;

    assign o_valid  = (r_cnt != '0);
    assign o_space2 = (r_cnt <= (AW+1)'(QUEUE_DEPTH - 2));
    assign o_data   = r_mem[r_head];
    assign pop      = o_valid && i_ready;

    // Fill count after this cycle's pushes and pop.
    assign n_cnt = r_cnt + (AW+1)'(i_push_n) - (AW+1)'(pop);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) r_mem[r_tail] <= i_data0;
        if (i_push_n == 2'd2) r_mem[r_tail + AW'(1)] <= i_data1;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_tail <= r_tail + AW'(i_push_n);
            if (pop) r_head <= r_head + AW'(1);
            r_cnt <= n_cnt;
        end
    end

    `SBT_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= (AW+1)'(QUEUE_DEPTH))
    `SBT_ASSERT_IMP(a_no_overfill, i_clk, i_rst_n, i_push_n != 2'd0, o_space2)
    `SBT_ASSERT_IMP(a_cnt_track, i_clk, i_rst_n, $past(i_rst_n), r_cnt == $past(n_cnt))

endmodule

@@ rtl/core/source_byte_tokenizer_top.sv @@
// Byte tokenizer top level. One byte is accepted per cycle while the result
// queue has room for two tokens; tokens are registered in that queue first.
// Tokens leave one per cycle while i_ready is high (single queue read port),
// so throughput is one byte per cycle when bytes average at most one token.
// Synchronous active-low reset returns the scanner to idle at offset zero.
`timescale 1ns / 1ps
module source_byte_tokenizer_top
    import sbt_pkg::*;
#(
    parameter int unsigned MAX_SOURCE_BYTES = MAX_SOURCE_BYTES_DEF,
    localparam int unsigned SW = $clog2(MAX_SOURCE_BYTES),
    localparam int unsigned PW = SW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte_value,
    input  logic          i_start_of_source,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [2:0]    o_token_class,
    output logic [7:0]    o_char_code,
    output logic [1:0]    o_radix_mark,
    output logic [63:0]   o_int_value,
    output logic [2:0]    o_keyword_index,
    output logic [SW-1:0] o_start_offset,
    output logic [PW-1:0] o_end_offset,
    output logic [2:0]    o_error_code,
    output logic          o_last_of_run
);

    localparam int unsigned DW = $bits(t_tok) + SW + PW + 1;

    logic          step;
    logic [1:0]    cnt;
    t_tok          tok0, tok1, tok_q;
    logic [SW-1:0] so0, so1;
    logic [PW-1:0] eo0, eo1;
    logic [DW-1:0] d0, d1, dq;

    assign step = i_valid && o_ready;

    sbt_scan #(.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step),
        .i_byte(i_byte_value), .i_sos(i_start_of_source),
        .o_count(cnt), .o_tok0(tok0), .o_tok1(tok1),
        .o_so0(so0), .o_so1(so1), .o_eo0(eo0), .o_eo1(eo1)
    );

    // The last token of a byte carries the run-end flag.
    assign d0 = {tok0, so0, eo0, cnt == 2'd1};
    assign d1 = {tok1, so1, eo1, 1'b1};

    sbt_outq #(.DATA_W(DW)) u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push_n(step ? cnt : 2'd0),
        .i_data0(d0), .i_data1(d1),
        .o_space2(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(dq)
    );

    assign {tok_q, o_start_offset, o_end_offset, o_last_of_run} = dq;
    assign o_token_class   = tok_q.cls;
    assign o_char_code     = tok_q.chr;
    assign o_radix_mark    = tok_q.rad;
    assign o_int_value     = tok_q.val;
    assign o_keyword_index = tok_q.kw;
    assign o_error_code    = tok_q.err;

endmodule
